>>> rtl/lazy_max_segment_tree_engine_unit_macros.svh
// assertion macros for the range-add / rightmost-search engine
`ifndef LAZY_MAX_SEGMENT_TREE_ENGINE_UNIT_MACROS_SVH
`define LAZY_MAX_SEGMENT_TREE_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LMST_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LMST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LMST_IMPLIES(lbl, ante, cons, msg)
`define LMST_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/lmst_pkg.sv
// ----------------------------------------------------------------------------
// lmst_pkg
// Shared types and constants of the range-add / rightmost-search engine.
// ----------------------------------------------------------------------------
`default_nettype none
package lmst_pkg;
	localparam int POSITIONS_DEF = 1024;
	localparam int POS_W   = 11;
	localparam int DATA_W  = 32;
	localparam int DELTA_W = 16;
	localparam int THR_W   = 31;
	localparam int CMD_W   = 3;

	localparam logic [POS_W-1:0] ACTIVE_RST    = 11'd1024;
	localparam logic [THR_W-1:0] THRESHOLD_RST = 31'd1;

	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD        = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MARK       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND_COUNT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND_MARK  = 3'd4;

	localparam logic REG_ACTIVE    = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef struct packed {
		logic latch;
		logic sweep_wr;
		logic rd;
		logic add_wr;
		logic mark_wr;
		logic ptr_inc;
		logic ptr_dec;
		logic res_found;
	} dp_cmd_t;

	typedef struct packed {
		logic ptr_le_hi;
		logic ptr_is_end;
		logic ptr_is_one;
		logic sweep_last;
		logic hit;
	} dp_stat_t;
endpackage
`default_nettype wire

>>> rtl/lmst_ctrl.sv
// ----------------------------------------------------------------------------
// lmst_ctrl
// Sequencer: clearing sweep, read-modify-write add loop, mark write, descending search.
// ----------------------------------------------------------------------------
`default_nettype none
module lmst_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lmst_pkg::CMD_W-1:0] command,
	input  wire lmst_pkg::dp_stat_t         stat,
	output lmst_pkg::dp_cmd_t               ctl,
	output logic                            busy,
	output logic                            done
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SWEEP, ST_ADD_RD, ST_ADD_WR, ST_MARK, ST_SRCH_RD, ST_SRCH_CMP, ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   from_cmd_q;
	logic   busy_q, done_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					unique case (command) inside
						lmst_pkg::CMD_CLEAR:      state_d = ST_SWEEP;
						lmst_pkg::CMD_ADD:        state_d = ST_ADD_RD;
						lmst_pkg::CMD_MARK:       state_d = ST_MARK;
						lmst_pkg::CMD_FIND_COUNT,
						lmst_pkg::CMD_FIND_MARK:  state_d = ST_SRCH_RD;
						default:                  state_d = ST_DONE;
					endcase
				end
			end
			ST_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (stat.sweep_last) state_d = from_cmd_q ? ST_DONE : ST_IDLE;
				else ctl.ptr_inc = 1'b1;
			end
			ST_ADD_RD: begin
				if (!stat.ptr_le_hi) state_d = ST_DONE;
				else begin
					ctl.rd  = 1'b1;
					state_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: begin
				ctl.add_wr = 1'b1;
				if (stat.ptr_is_end) state_d = ST_DONE;
				else begin
					ctl.ptr_inc = 1'b1;
					state_d     = ST_ADD_RD;
				end
			end
			ST_MARK: begin
				ctl.mark_wr = 1'b1;
				state_d     = ST_DONE;
			end
			ST_SRCH_RD: begin
				ctl.rd  = 1'b1;
				state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (stat.hit) begin
					ctl.res_found = 1'b1;
					state_d       = ST_DONE;
				end else if (stat.ptr_is_one) state_d = ST_DONE;
				else begin
					ctl.ptr_dec = 1'b1;
					state_d     = ST_SRCH_RD;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// reset starts a silent clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			from_cmd_q <= 1'b0;
			busy_q     <= 1'b1;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= (state_d == ST_DONE);
			if (ctl.latch) from_cmd_q <= 1'b1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> rtl/lmst_datapath.sv
// ----------------------------------------------------------------------------
// lmst_datapath
// Count and mark memories, position pointer, saturating add, compare, result.
// ----------------------------------------------------------------------------
`default_nettype none
module lmst_datapath #(
	parameter int POSITIONS = lmst_pkg::POSITIONS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lmst_pkg::dp_cmd_t            ctl,
	output lmst_pkg::dp_stat_t                stat,
	input  wire logic [lmst_pkg::CMD_W-1:0]   command,
	input  wire logic [lmst_pkg::POS_W-1:0]   low_pos,
	input  wire logic [lmst_pkg::POS_W-1:0]   high_pos,
	input  wire logic signed [lmst_pkg::DELTA_W-1:0] delta,
	input  wire logic [lmst_pkg::POS_W-1:0]   mark_pos,
	input  wire logic signed [lmst_pkg::DATA_W-1:0]  mark_value,
	input  wire logic signed [lmst_pkg::DATA_W-1:0]  search_key,
	input  wire logic [lmst_pkg::POS_W-1:0]   active_size,
	input  wire logic [lmst_pkg::THR_W-1:0]   threshold,
	output logic                              found,
	output logic [lmst_pkg::POS_W-1:0]        position
);
	localparam int AW = $clog2(POSITIONS);
	localparam int PW = $clog2(POSITIONS + 1);
	localparam int XW = (PW > lmst_pkg::POS_W) ? PW : lmst_pkg::POS_W;
	localparam int DW = lmst_pkg::DATA_W;
	localparam int LIVE_RST = (POSITIONS < 1024) ? POSITIONS : 1024;

	logic [DW-1:0] cnt_mem  [POSITIONS];
	logic [DW-1:0] mark_mem [POSITIONS];

	logic [XW-1:0] ptr_q, hi_q, live_q;
	logic [lmst_pkg::CMD_W-1:0] cmd_q;
	logic signed [lmst_pkg::DELTA_W-1:0] delta_q;
	logic signed [DW-1:0] mval_q, key_q, rd_cnt_q, rd_mark_q;
	logic found_q;
	logic [XW-1:0] position_q;

	logic [XW-1:0] lo_x, hi_x, mp_x, as_x, lim_x, live_use;
	logic [AW-1:0] addr;
	logic signed [DW:0] sum;
	logic [DW-1:0] sat;
	logic mark_ok, cnt_we, mark_we;
	logic [DW-1:0] cnt_wd, mark_wd;

	always_comb begin
		as_x = XW'(active_size);
		if (as_x == '0) lim_x = XW'(1);
		else if (as_x > XW'(POSITIONS)) lim_x = XW'(POSITIONS);
		else lim_x = as_x;
		// a clear in the same transaction latches the new size
		live_use = (command == lmst_pkg::CMD_CLEAR) ? lim_x : live_q;
		lo_x = (low_pos == '0) ? XW'(1) : XW'(low_pos);
		hi_x = (XW'(high_pos) > live_q) ? live_q : XW'(high_pos);
		mp_x = XW'(mark_pos);
	end

	assign addr    = AW'(ptr_q - XW'(1));
	assign mark_ok = (ptr_q != '0) && (ptr_q <= live_q);

	// saturating add on a 33-bit sum
	always_comb begin
		sum = {rd_cnt_q[DW-1], rd_cnt_q} + (DW+1)'(delta_q);
		if (sum[DW] != sum[DW-1]) sat = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		else sat = sum[DW-1:0];
	end

	assign cnt_we  = ctl.sweep_wr || ctl.add_wr;
	assign cnt_wd  = ctl.sweep_wr ? '0 : sat;
	assign mark_we = ctl.sweep_wr || (ctl.mark_wr && mark_ok);
	assign mark_wd = ctl.sweep_wr ? '1 : mval_q;

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[addr] <= cnt_wd;
		if (ctl.rd) rd_cnt_q <= cnt_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[addr] <= mark_wd;
		if (ctl.rd) rd_mark_q <= mark_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= command;
			delta_q <= delta;
			mval_q  <= mark_value;
			key_q   <= search_key;
			hi_q    <= hi_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= XW'(1);
			live_q     <= XW'(LIVE_RST);
			found_q    <= 1'b0;
			position_q <= '0;
		end else begin
			if (ctl.latch) begin
				found_q    <= 1'b0;
				position_q <= '0;
				live_q     <= live_use;
				case (command)
					lmst_pkg::CMD_CLEAR: ptr_q <= XW'(1);
					lmst_pkg::CMD_ADD:   ptr_q <= lo_x;
					lmst_pkg::CMD_MARK:  ptr_q <= mp_x;
					default:             ptr_q <= live_use;
				endcase
			end else if (ctl.ptr_inc) ptr_q <= ptr_q + XW'(1);
			else if (ctl.ptr_dec) ptr_q <= ptr_q - XW'(1);
			if (ctl.res_found) begin
				found_q    <= 1'b1;
				position_q <= ptr_q;
			end
		end
	end

	always_comb begin
		stat.ptr_le_hi  = (ptr_q <= hi_q);
		stat.ptr_is_end = (ptr_q == hi_q);
		stat.ptr_is_one = (ptr_q == XW'(1));
		stat.sweep_last = (ptr_q == XW'(POSITIONS));
		if (cmd_q == lmst_pkg::CMD_FIND_MARK) stat.hit = (rd_mark_q >= key_q);
		else stat.hit = ($signed({rd_cnt_q[DW-1], rd_cnt_q}) >=
				$signed({2'b00, threshold}));
	end

	assign found    = found_q;
	assign position = lmst_pkg::POS_W'(position_q);
endmodule
`default_nettype wire

>>> rtl/lazy_max_segment_tree_engine_unit.sv
// ----------------------------------------------------------------------------
// lazy_max_segment_tree_engine_unit
// Range add with saturation, point mark set, rightmost count/mark search.
//
// channel  | signals                                   | transfer
// command  | start, busy, command ... search_key       | start && !busy
// result   | done, found, position                      | done, one cycle
// config   | psel penable pwrite paddr pwdata prdata   | psel&penable&pwrite
//
// clear writes all positions; range add reads then writes each position in
// range, none if the range is empty; set mark writes at most one position;
// searches read from the top down; unknown commands do nothing. One memory
// access per cycle. After reset a clearing sweep runs with busy high.
// results cannot be stalled; done pulses one cycle, found/position hold after.
// ----------------------------------------------------------------------------
`default_nettype none
module lazy_max_segment_tree_engine_unit #(
	parameter int POSITIONS = lmst_pkg::POSITIONS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [lmst_pkg::CMD_W-1:0]          command,
	input  wire logic [lmst_pkg::POS_W-1:0]          low_pos,
	input  wire logic [lmst_pkg::POS_W-1:0]          high_pos,
	input  wire logic signed [lmst_pkg::DELTA_W-1:0] delta,
	input  wire logic [lmst_pkg::POS_W-1:0]          mark_pos,
	input  wire logic signed [lmst_pkg::DATA_W-1:0]  mark_value,
	input  wire logic signed [lmst_pkg::DATA_W-1:0]  search_key,
	output logic                                     done,
	output logic                                     found,
	output logic [lmst_pkg::POS_W-1:0]               position,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);
	lmst_pkg::dp_cmd_t  ctl;
	lmst_pkg::dp_stat_t stat;
	logic [lmst_pkg::POS_W-1:0] active_q;
	logic [lmst_pkg::THR_W-1:0] thr_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lmst_pkg::ACTIVE_RST;
			thr_q    <= lmst_pkg::THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				lmst_pkg::REG_ACTIVE:    active_q <= pwdata[lmst_pkg::POS_W-1:0];
				lmst_pkg::REG_THRESHOLD: thr_q    <= pwdata[lmst_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lmst_pkg::REG_ACTIVE:    prdata = 32'(active_q);
			lmst_pkg::REG_THRESHOLD: prdata = 32'(thr_q);
			default:                 prdata = '0;
		endcase
	end

	lmst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done)
	);

	lmst_datapath #(.POSITIONS(POSITIONS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.command     (command),
		.low_pos     (low_pos),
		.high_pos    (high_pos),
		.delta       (delta),
		.mark_pos    (mark_pos),
		.mark_value  (mark_value),
		.search_key  (search_key),
		.active_size (active_q),
		.threshold   (thr_q),
		.found       (found),
		.position    (position)
	);

`include "lazy_max_segment_tree_engine_unit_macros.svh"

	`LMST_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`LMST_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	`LMST_IMPLIES(a_done_busy, done, busy, "done outside a transaction")
	`LMST_IMPLIES(a_found_pos, done && found, position != '0, "found at position zero")
	`LMST_IMPLIES(a_none_pos, done && !found, position == '0, "position set without a hit")
endmodule
`default_nettype wire

>>> tb/lazy_max_segment_tree_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lazy_max_segment_tree_engine_unit_tb
// Self-checking bench for the range-add / rightmost-search engine. A
// scoreboard keeps per-position counts and marks, predicts each command's
// search result and compares it with what the engine reports. Stimulus
// covers field extremes, several active sizes and thresholds, random
// commands, and add chains at the extreme deltas.
// ----------------------------------------------------------------------------
`default_nettype none
module lazy_max_segment_tree_engine_unit_tb;
	localparam int NPOS = lmst_pkg::POSITIONS_DEF;
	localparam logic [2:0] ADDR_ACTIVE    = {lmst_pkg::REG_ACTIVE, 2'b00};
	localparam logic [2:0] ADDR_THRESHOLD = {lmst_pkg::REG_THRESHOLD, 2'b00};
	localparam logic [lmst_pkg::CMD_W-1:0] CMD_LAST = lmst_pkg::CMD_FIND_MARK;
	localparam int SAT_STEPS = 12;

	typedef struct {
		logic [lmst_pkg::CMD_W-1:0]          cmd;
		logic [lmst_pkg::POS_W-1:0]          lo;
		logic [lmst_pkg::POS_W-1:0]          hi;
		logic signed [lmst_pkg::DELTA_W-1:0] delta;
		logic [lmst_pkg::POS_W-1:0]          mpos;
		logic signed [lmst_pkg::DATA_W-1:0]  mval;
		logic signed [lmst_pkg::DATA_W-1:0]  key;
	} cmd_item_t;

	typedef struct packed {
		logic                       found;
		logic [lmst_pkg::POS_W-1:0] position;
	} search_result_t;

	class search_scoreboard;
		int count_at[NPOS+1];
		int mark_at[NPOS+1];
		int live;
		logic [lmst_pkg::POS_W-1:0] size_reg;
		logic [lmst_pkg::THR_W-1:0] thr_reg;
		search_result_t pending[$];
		int errors;

		function new();
			size_reg = lmst_pkg::ACTIVE_RST;
			thr_reg = lmst_pkg::THRESHOLD_RST;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			live = (size_reg == 0) ? 1 : (size_reg > NPOS) ? NPOS : int'(size_reg);
			for (int p = 0; p <= NPOS; p++) begin
				count_at[p] = 0;
				mark_at[p] = -1;
			end
		endfunction

		function void note_command(cmd_item_t c);
			search_result_t r;
			int lo;
			int hi;
			longint v;
			r = '0;
			case (c.cmd)
				lmst_pkg::CMD_CLEAR: wipe();
				lmst_pkg::CMD_ADD: begin
					lo = (c.lo == 0) ? 1 : int'(c.lo);
					hi = (c.hi > live) ? live : int'(c.hi);
					for (int p = lo; p <= hi; p++) begin
						v = longint'(count_at[p]) + longint'(c.delta);
						if (v > 64'sd2147483647) v = 64'sd2147483647;
						if (v < -64'sd2147483648) v = -64'sd2147483648;
						count_at[p] = int'(v);
					end
				end
				lmst_pkg::CMD_MARK: begin
					if (c.mpos >= 1 && c.mpos <= live) mark_at[c.mpos] = c.mval;
				end
				lmst_pkg::CMD_FIND_COUNT: begin
					for (int p = live; p >= 1; p--) begin
						if (longint'(count_at[p]) >= longint'({1'b0, thr_reg})) begin
							r.found = 1'b1;
							r.position = lmst_pkg::POS_W'(p);
							break;
						end
					end
				end
				lmst_pkg::CMD_FIND_MARK: begin
					for (int p = live; p >= 1; p--) begin
						if (mark_at[p] >= c.key) begin
							r.found = 1'b1;
							r.position = lmst_pkg::POS_W'(p);
							break;
						end
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic f, logic [lmst_pkg::POS_W-1:0] pos);
			search_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: found %0d position %0d", f, pos);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (f !== e.found) begin
				$error("found: expected %0d, actual %0d", e.found, f);
				errors++;
			end
			if (pos !== e.position) begin
				$error("position: expected %0d, actual %0d", e.position, pos);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [lmst_pkg::CMD_W-1:0] command;
	logic [lmst_pkg::POS_W-1:0] low_pos;
	logic [lmst_pkg::POS_W-1:0] high_pos;
	logic signed [lmst_pkg::DELTA_W-1:0] delta;
	logic [lmst_pkg::POS_W-1:0] mark_pos;
	logic signed [lmst_pkg::DATA_W-1:0] mark_value;
	logic signed [lmst_pkg::DATA_W-1:0] search_key;
	logic done;
	logic found;
	logic [lmst_pkg::POS_W-1:0] position;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	search_scoreboard sb = new();
	bit idle_on = 1'b1;

	always #2 clk = ~clk;

	lazy_max_segment_tree_engine_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .low_pos(low_pos), .high_pos(high_pos), .delta(delta),
		.mark_pos(mark_pos), .mark_value(mark_value), .search_key(search_key),
		.done(done), .found(found), .position(position),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(found, position);
	end

	function automatic cmd_item_t mk(logic [lmst_pkg::CMD_W-1:0] c, int lo = 1, int hi = 1,
		int d = 0, int mp = 1, int mv = -1, int k = -1);
		cmd_item_t t;
		t.cmd = c;
		t.lo = lmst_pkg::POS_W'(lo);
		t.hi = lmst_pkg::POS_W'(hi);
		t.delta = lmst_pkg::DELTA_W'(d);
		t.mpos = lmst_pkg::POS_W'(mp);
		t.mval = mv;
		t.key = k;
		return t;
	endfunction

	function automatic cmd_item_t random_cmd(int live);
		cmd_item_t t;
		int pick;
		int a;
		int b;
		pick = $urandom_range(99);
		t = mk(lmst_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
		if (pick < 2) t.cmd = lmst_pkg::CMD_CLEAR;
		else if (pick < 32) t.cmd = lmst_pkg::CMD_ADD;
		else if (pick < 55) t.cmd = lmst_pkg::CMD_MARK;
		else if (pick < 74) t.cmd = lmst_pkg::CMD_FIND_COUNT;
		else if (pick < 93) t.cmd = lmst_pkg::CMD_FIND_MARK;
		else t.cmd = lmst_pkg::CMD_W'(CMD_LAST + $urandom_range(1, 3));
		if ($urandom_range(9) != 0) begin
			a = $urandom_range(1, live);
			b = $urandom_range(1, live);
			t.lo = lmst_pkg::POS_W'((a < b) ? a : b);
			t.hi = lmst_pkg::POS_W'((a < b) ? b : a);
			t.mpos = lmst_pkg::POS_W'($urandom_range(1, live));
		end
		if ($urandom_range(1)) t.delta = lmst_pkg::DELTA_W'($urandom_range(0, 12) - 4);
		if ($urandom_range(3) != 0) begin
			t.mval = $urandom_range(0, 40) - 1;
			t.key = $urandom_range(0, 40) - 1;
		end
		return t;
	endfunction

	task automatic send(cmd_item_t t);
		start <= 1'b1;
		command <= t.cmd;
		low_pos <= t.lo;
		high_pos <= t.hi;
		delta <= t.delta;
		mark_pos <= t.mpos;
		mark_value <= t.mval;
		search_key <= t.key;
		do @(posedge clk); while (busy);
		sb.note_command(t);
	endtask

	task automatic idle_maybe();
		if (idle_on && $urandom_range(99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// let every outstanding transaction finish before touching registers
	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ACTIVE) sb.size_reg = value[lmst_pkg::POS_W-1:0];
		else sb.thr_reg = value[lmst_pkg::THR_W-1:0];
		@(posedge clk);
	endtask

	task automatic run_phase(int size, logic [31:0] thr, int n);
		cfg_write(ADDR_ACTIVE, size);
		cfg_write(ADDR_THRESHOLD, thr);
		send(mk(lmst_pkg::CMD_CLEAR));
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) settle();
			send(random_cmd(sb.live));
			idle_maybe();
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = lmst_pkg::CMD_CLEAR;
		low_pos = '0;
		high_pos = '0;
		delta = '0;
		mark_pos = '0;
		mark_value = '0;
		search_key = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and the corner cases at reset size
		send(mk(lmst_pkg::CMD_FIND_COUNT));
		send(mk(lmst_pkg::CMD_ADD, 1, 1024, 5));
		send(mk(lmst_pkg::CMD_ADD, 0, 2047, -32768));
		send(mk(lmst_pkg::CMD_ADD, 900, 10, 100));
		send(mk(lmst_pkg::CMD_ADD, 1024, 1024, 32767));
		idle_maybe();
		send(mk(lmst_pkg::CMD_FIND_COUNT));
		send(mk(lmst_pkg::CMD_MARK, 0, 0, 0, 0, 77));
		send(mk(lmst_pkg::CMD_MARK, 0, 0, 0, 2047, 77));
		send(mk(lmst_pkg::CMD_MARK, 0, 0, 0, 1024, 32'h7fffffff));
		send(mk(lmst_pkg::CMD_MARK, 0, 0, 0, 1, -5));
		send(mk(lmst_pkg::CMD_MARK, 0, 0, 0, 512, -1));
		send(mk(lmst_pkg::CMD_MARK, 0, 0, 0, 3, 32'h80000000));
		send(mk(lmst_pkg::CMD_FIND_MARK, 0, 0, 0, 0, 0, 32'h7fffffff));
		send(mk(lmst_pkg::CMD_FIND_MARK, 0, 0, 0, 0, 0, 0));
		send(mk(lmst_pkg::CMD_FIND_MARK, 0, 0, 0, 0, 0, -1));
		send(mk(lmst_pkg::CMD_FIND_MARK, 0, 0, 0, 0, 0, 32'h80000000));
		send(mk(lmst_pkg::CMD_W'(CMD_LAST + 1)));
		send(mk(lmst_pkg::CMD_W'(CMD_LAST + 2)));
		send(mk(lmst_pkg::CMD_W'(CMD_LAST + 3), 2047, 2047, -1, 2047, -1, -1));
		send(mk(lmst_pkg::CMD_CLEAR));
		send(mk(lmst_pkg::CMD_FIND_MARK, 0, 0, 0, 0, 0, -1));
		settle();

		run_phase(1, 0, 100);
		idle_on = 1'b0;
		run_phase(16, 1, 150);
		idle_on = 1'b1;
		run_phase(16, 3, 250);
		run_phase(0, 32'h7fffffff, 60);
		run_phase(2047, $urandom_range(0, 20), 40);
		run_phase(37, $urandom_range(0, 6), 350);
		run_phase(1024, 32'hffffffff, 30);

		// add chains at the extreme deltas on two positions
		idle_on = 1'b0;
		cfg_write(ADDR_ACTIVE, 2);
		cfg_write(ADDR_THRESHOLD, 32'h7fffffff);
		send(mk(lmst_pkg::CMD_CLEAR));
		repeat (SAT_STEPS) send(mk(lmst_pkg::CMD_ADD, 1, 1, 32767));
		send(mk(lmst_pkg::CMD_FIND_COUNT));
		send(mk(lmst_pkg::CMD_ADD, 1, 2, -32768));
		send(mk(lmst_pkg::CMD_FIND_COUNT));
		send(mk(lmst_pkg::CMD_ADD, 1, 1, 32767));
		repeat (SAT_STEPS) send(mk(lmst_pkg::CMD_ADD, 2, 2, -32768));
		settle();
		cfg_write(ADDR_THRESHOLD, 0);
		send(mk(lmst_pkg::CMD_FIND_COUNT));
		send(mk(lmst_pkg::CMD_ADD, 2, 2, 32767));
		send(mk(lmst_pkg::CMD_FIND_COUNT));
		settle();

		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("lazy_max_segment_tree_engine_unit verification clean");
		end else begin
			$display("lazy_max_segment_tree_engine_unit verification failed");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("lazy_max_segment_tree_engine_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
